@@ sv/tisa_pkg.sv @@
// Shared types, opcodes and status codes for the tagged integer stack ALU.
// No dependencies.
package tisa_pkg;

    localparam logic [7:0] OP_CONST0   = 8'd99;
    localparam logic [7:0] OP_CONSTI   = 8'd103;
    localparam logic [7:0] OP_PUSH0    = 8'd104;
    localparam logic [7:0] OP_PUSHI    = 8'd108;
    localparam logic [7:0] OP_NEG      = 8'd109;
    localparam logic [7:0] OP_ADD      = 8'd110;
    localparam logic [7:0] OP_SUB      = 8'd111;
    localparam logic [7:0] OP_MUL      = 8'd112;
    localparam logic [7:0] OP_DIV      = 8'd113;
    localparam logic [7:0] OP_MOD      = 8'd114;
    localparam logic [7:0] OP_AND      = 8'd115;
    localparam logic [7:0] OP_OR       = 8'd116;
    localparam logic [7:0] OP_XOR      = 8'd117;
    localparam logic [7:0] OP_LSL      = 8'd118;
    localparam logic [7:0] OP_LSR      = 8'd119;
    localparam logic [7:0] OP_ASR      = 8'd120;
    localparam logic [7:0] OP_EQ       = 8'd121;
    localparam logic [7:0] OP_NE       = 8'd122;
    localparam logic [7:0] OP_LT       = 8'd123;
    localparam logic [7:0] OP_LE       = 8'd124;
    localparam logic [7:0] OP_GT       = 8'd125;
    localparam logic [7:0] OP_GE       = 8'd126;
    localparam logic [7:0] OP_OFFSET   = 8'd127;
    localparam logic [7:0] OP_ISINT    = 8'd129;
    localparam logic [7:0] OP_BEQ      = 8'd131;
    localparam logic [7:0] OP_BNE      = 8'd132;
    localparam logic [7:0] OP_BLT      = 8'd133;
    localparam logic [7:0] OP_BLE      = 8'd134;
    localparam logic [7:0] OP_BGT      = 8'd135;
    localparam logic [7:0] OP_BGE      = 8'd136;
    localparam logic [7:0] OP_ULT      = 8'd137;
    localparam logic [7:0] OP_UGE      = 8'd138;
    localparam logic [7:0] OP_BULT     = 8'd139;
    localparam logic [7:0] OP_BUGE     = 8'd140;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    localparam logic [63:0] TAG_TRUE  = 64'd3;
    localparam logic [63:0] TAG_FALSE = 64'd1;

    // instruction class decided by the front end
    localparam logic [2:0] CL_NOP    = 3'd0;
    localparam logic [2:0] CL_CONST  = 3'd1;
    localparam logic [2:0] CL_PUSH   = 3'd2;
    localparam logic [2:0] CL_BINOP  = 3'd3;
    localparam logic [2:0] CL_UNARY  = 3'd4;
    localparam logic [2:0] CL_BRANCH = 3'd5;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [2:0]  cls;
        logic [63:0] imm;    // sign extended immediate
        logic [32:0] ofs;    // sign extended offset
        logic [32:0] step;   // step on success / not taken
    } dec_item_t;

    function automatic logic [63:0] tf(input logic b);
        return b ? TAG_TRUE : TAG_FALSE;
    endfunction

endpackage

@@ sv/tisa_front.sv @@
// Front end: accepts instructions and classifies them into decoded items.
// Depends on tisa_pkg.
module tisa_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_cmd,
    input  logic [31:0]          in_imm,
    input  logic [31:0]          in_ofs,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tisa_pkg::dec_item_t  q_item
);
    import tisa_pkg::*;

    dec_item_t d;
    dec_item_t buf_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    always_comb begin
        d.cmd  = in_cmd;
        d.imm  = {{32{in_imm[31]}}, in_imm};
        d.ofs  = {in_ofs[31], in_ofs};
        d.step = 33'd0;
        d.cls  = CL_NOP;
        if (in_cmd >= OP_CONST0 && in_cmd <= OP_CONSTI) begin
            d.cls = CL_CONST;
        end else if (in_cmd >= OP_PUSH0 && in_cmd <= OP_PUSHI) begin
            d.cls = CL_PUSH;
        end else if ((in_cmd >= OP_ADD && in_cmd <= OP_GE) || in_cmd == OP_ULT
                     || in_cmd == OP_UGE) begin
            d.cls = CL_BINOP;
        end else if (in_cmd == OP_NEG || in_cmd == OP_OFFSET || in_cmd == OP_ISINT) begin
            d.cls = CL_UNARY;
        end else if ((in_cmd >= OP_BEQ && in_cmd <= OP_BGE) || in_cmd == OP_BULT
                     || in_cmd == OP_BUGE) begin
            d.cls  = CL_BRANCH;
            d.step = 33'd2;
        end
        if (in_cmd == OP_CONSTI || in_cmd == OP_PUSHI || in_cmd == OP_OFFSET) begin
            d.step = 33'd1;
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wp_reg] <= d;
        end
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> (wp_reg == rp_reg))
        else $error("queue pointers differ while empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not advance");
endmodule

@@ sv/tisa_div.sv @@
// Radix-2 restoring divider on 64-bit magnitudes, one quotient bit a cycle.
// Depends on tisa_pkg for house conventions only.
module tisa_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo,
    output logic [63:0] rem
);
    import tisa_pkg::*;

    logic [63:0] q_reg, r_reg, d_reg;
    logic [6:0]  n_reg;
    logic        busy_reg;
    logic [64:0] trial;
    logic [64:0] shr;

    assign shr   = {r_reg, q_reg[63]};
    assign trial = shr - {1'b0, d_reg};
    assign quo   = q_reg;
    assign rem   = r_reg;
    assign done  = busy_reg && (n_reg == 7'd0);

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= num;
            r_reg <= 64'd0;
            d_reg <= den;
        end else if (busy_reg && n_reg != 7'd0) begin
            if (!trial[64]) begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end else begin
                r_reg <= shr[63:0];
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg    <= 7'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            n_reg    <= 7'd64;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            n_reg <= n_reg - 7'd1;
        end
    end
endmodule

@@ sv/tisa_back.sv @@
// Back end: executes decoded items on the accumulator and operand stack.
// Depends on tisa_pkg and tisa_div.
module tisa_back #(
    parameter int STACK_DEPTH = 256,
    parameter int CW          = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  tisa_pkg::dec_item_t  q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          out_acc,
    output logic [32:0]          out_step,
    output logic [1:0]           out_status
);
    import tisa_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DIVW = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] m_reg, acc_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]  state_reg;
    dec_item_t   it_reg;
    logic [32:0] step_reg;
    logic [1:0]  stat_reg;
    logic [63:0] pp_reg [3];

    logic [63:0] a, b, n, sum;
    logic        b_big;
    logic [5:0]  sh;
    logic [63:0] shl, lsr, asr;
    logic        slt_am, slt_ma, slt_in, slt_ni;
    logic        taken;
    logic [63:0] ma, mb;
    logic        dstart, ddone;
    logic [63:0] dquo, drem;
    logic [63:0] exec_res;
    logic [63:0] mulsum;
    logic [63:0] neg_a, div_res;

    assign a = {acc_reg[63], acc_reg[63:1]};
    assign b = {m_reg[63], m_reg[63:1]};
    assign n = a;
    assign b_big  = (b >= 64'd63);
    assign sh     = b[5:0];
    assign shl    = a << sh;
    assign lsr    = (acc_reg >> 1) >> sh;
    assign asr    = $unsigned($signed(a) >>> sh);
    assign slt_am = $signed(acc_reg) < $signed(m_reg);
    assign slt_ma = $signed(m_reg) < $signed(acc_reg);
    assign slt_in = $signed(it_reg.imm) < $signed(n);
    assign slt_ni = $signed(n) < $signed(it_reg.imm);
    assign ma = a[63] ? (64'd0 - a) : a;
    assign mb = b[63] ? (64'd0 - b) : b;
    assign sum = a + b;
    assign mulsum = pp_reg[0] + ((pp_reg[1] + pp_reg[2]) << 32);
    assign neg_a = 64'd0 - a;
    assign div_res = (it_reg.cmd == OP_DIV) ?
        ((a[63] != b[63]) ? (64'd0 - dquo) : dquo) :
        (a[63] ? (64'd0 - drem) : drem);

    always_comb begin
        taken = 1'b0;
        case (it_reg.cmd)
            OP_BEQ:  taken = (it_reg.imm == n);
            OP_BNE:  taken = (it_reg.imm != n);
            OP_BLT:  taken = slt_in;
            OP_BLE:  taken = !slt_ni;
            OP_BGT:  taken = slt_ni;
            OP_BGE:  taken = !slt_in;
            OP_BULT: taken = (it_reg.imm < n);
            OP_BUGE: taken = (it_reg.imm >= n);
            default: taken = 1'b0;
        endcase
    end

    always_comb begin
        exec_res = acc_reg;
        case (it_reg.cmd)
            OP_ADD:  exec_res = {sum[62:0], 1'b1};
            OP_SUB:  exec_res = {a[62:0] - b[62:0], 1'b1};
            OP_AND:  exec_res = {a[62:0] & b[62:0], 1'b1};
            OP_OR:   exec_res = {a[62:0] | b[62:0], 1'b1};
            OP_XOR:  exec_res = {a[62:0] ^ b[62:0], 1'b1};
            OP_LSL:  exec_res = b_big ? 64'd1 : {shl[62:0], 1'b1};
            OP_LSR:  exec_res = b_big ? 64'd1 : {lsr[62:0], 1'b1};
            OP_ASR:  exec_res = b_big ? {{63{a[63]}}, 1'b1} : {asr[62:0], 1'b1};
            OP_EQ:   exec_res = tf(acc_reg == m_reg);
            OP_NE:   exec_res = tf(acc_reg != m_reg);
            OP_LT:   exec_res = tf(slt_am);
            OP_LE:   exec_res = tf(!slt_ma);
            OP_GT:   exec_res = tf(slt_ma);
            OP_GE:   exec_res = tf(!slt_am);
            OP_ULT:  exec_res = tf(acc_reg < m_reg);
            OP_UGE:  exec_res = tf(acc_reg >= m_reg);
            OP_NEG:  exec_res = {neg_a[62:0], 1'b1};
            OP_OFFSET: exec_res = {a[62:0] + it_reg.imm[62:0], 1'b1};
            OP_ISINT: exec_res = tf(acc_reg[0]);
            default: exec_res = acc_reg;
        endcase
    end

    assign dstart = (state_reg == S_DIV);
    tisa_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart),
        .num(ma), .den(mb), .done(ddone), .quo(dquo), .rem(drem)
    );

    assign q_ready    = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_acc    = acc_reg;
    assign out_step   = step_reg;
    assign out_status = stat_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_READ) begin
            m_reg <= mem[cnt_reg[AW-1:0]];
        end
        if (state_reg == S_IDLE && q_valid && q_item.cls == CL_PUSH
            && cnt_reg < CW'(STACK_DEPTH)) begin
            mem[cnt_reg[AW-1:0]] <= acc_reg;
        end
        if (state_reg == S_EXEC) begin
            pp_reg[0] <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
            pp_reg[1] <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
            pp_reg[2] <= {32'd0, a[31:0]} * {32'd0, b[63:32]};
        end
        if (!aresetn) begin
            state_reg <= S_IDLE;
            acc_reg   <= 64'd1;
            cnt_reg   <= '0;
            step_reg  <= '0;
            stat_reg  <= ST_OK;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        it_reg    <= q_item;
                        step_reg  <= q_item.step;
                        stat_reg  <= ST_OK;
                        state_reg <= S_OUT;
                        case (q_item.cls)
                            CL_CONST: begin
                                acc_reg <= (q_item.cmd == OP_CONSTI) ?
                                    {q_item.imm[62:0], 1'b1} :
                                    {55'd0, q_item.cmd - OP_CONST0, 1'b1};
                            end
                            CL_PUSH: begin
                                if (cnt_reg >= CW'(STACK_DEPTH)) begin
                                    stat_reg <= ST_OVER;
                                end else begin
                                    cnt_reg <= cnt_reg + CW'(1);
                                    acc_reg <= (q_item.cmd == OP_PUSHI) ?
                                        {q_item.imm[62:0], 1'b1} :
                                        {55'd0, q_item.cmd - OP_PUSH0, 1'b1};
                                end
                            end
                            CL_BINOP: begin
                                if (cnt_reg == '0) begin
                                    stat_reg <= ST_UNDER;
                                end else begin
                                    cnt_reg   <= cnt_reg - CW'(1);
                                    state_reg <= S_READ;
                                end
                            end
                            CL_UNARY, CL_BRANCH: state_reg <= S_EXEC;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_READ: state_reg <= S_EXEC;
                S_EXEC: begin
                    if (it_reg.cls == CL_BRANCH) begin
                        if (taken) step_reg <= 33'd1 + it_reg.ofs;
                        state_reg <= S_OUT;
                    end else if (it_reg.cmd == OP_MUL) begin
                        state_reg <= S_MUL;
                    end else if (it_reg.cmd == OP_DIV || it_reg.cmd == OP_MOD) begin
                        if (b == 64'd0) begin
                            stat_reg  <= ST_DIV0;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end else begin
                        acc_reg   <= exec_res;
                        state_reg <= S_OUT;
                    end
                end
                S_MUL: begin
                    acc_reg   <= {mulsum[62:0], 1'b1};
                    state_reg <= S_OUT;
                end
                S_DIV: state_reg <= S_DIVW;
                S_DIVW: begin
                    if (ddone) begin
                        acc_reg   <= {div_res[62:0], 1'b1};
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !out_ready) |=> (state_reg == S_OUT && $stable(acc_reg)))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (out_status != ST_DIV0 || it_reg.cmd == OP_DIV
                                  || it_reg.cmd == OP_MOD))
        else $error("division status on other opcode");
endmodule

@@ sv/tagged_integer_stack_alu.sv @@
// Tagged integer stack ALU. Constants, pushes, failed pops and unknown opcodes go
// from IDLE straight to OUT; unary ops and branches pass EXEC, binary ops READ and EXEC,
// multiply adds MUL, div/mod add DIV and DIVW while the divider runs (one bit a cycle).
// The back end runs one instruction at a time, while the two-entry front queue takes more.
// Reset: synchronous active-low aresetn; accumulator to 1, stack empty, queue empty.
// Depends on tisa_pkg, tisa_front, tisa_back, tisa_div.
module tagged_integer_stack_alu #(
    parameter int STACK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // command[7:0], immediate[39:8], branch_offset[71:40]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [99:0] m_tdata    // acc_value[63:0], index_step[96:64], status[98:97]
);
    import tisa_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic      q_valid, q_ready;
    dec_item_t q_item;
    logic [63:0] acc;
    logic [32:0] step;
    logic [1:0]  st;

    // front end: classify and queue requests
    tisa_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[7:0]), .in_imm(s_tdata[39:8]), .in_ofs(s_tdata[71:40]),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    // back end: execute against accumulator and stack, hold result until taken
    tisa_back #(.STACK_DEPTH(STACK_DEPTH), .CW(CW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_acc(acc), .out_step(step), .out_status(st)
    );

    assign m_tdata = {1'b0, st, step, acc};
endmodule

@@ sim/tisa_checker.sv @@
// Predicts and checks every result of the tagged integer stack ALU.
// Depends on tisa_pkg; watches the request and result channels only.
module tisa_checker #(
    parameter int STACK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [99:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    import tisa_pkg::*;

    typedef struct packed {
        logic [63:0] acc;
        logic [32:0] step;
        logic [1:0]  status;
    } alu_result_t;

    logic [63:0] acc_model;
    logic [63:0] stack_model [STACK_DEPTH];
    int          depth_model;
    alu_result_t result_queue[$];

    localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] untag(input logic [63:0] w);
        return {w[63], w[63:1]};
    endfunction

    function automatic logic [63:0] tag(input logic [63:0] n);
        return {n[62:0], 1'b1};
    endfunction

    function automatic logic signed_less(input logic [63:0] a, input logic [63:0] b);
        return (a ^ SIGN) < (b ^ SIGN);
    endfunction

    // Execute one instruction on the model state and return its result.
    function automatic alu_result_t execute(input logic [71:0] req);
        logic [7:0]  cmd;
        logic [63:0] imm, a, b, m, ma, mb, r, n;
        logic [32:0] ofs;
        logic        taken;
        alu_result_t res;
        cmd = req[7:0];
        imm = {{32{req[39]}}, req[39:8]};
        ofs = {req[71], req[71:40]};
        res.step = '0;
        res.status = ST_OK;
        if (cmd >= OP_CONST0 && cmd <= OP_CONSTI) begin
            if (cmd == OP_CONSTI) res.step = 33'd1;
            acc_model = tag(cmd == OP_CONSTI ? imm : 64'(cmd - OP_CONST0));
        end else if (cmd >= OP_PUSH0 && cmd <= OP_PUSHI) begin
            if (cmd == OP_PUSHI) res.step = 33'd1;
            if (depth_model >= STACK_DEPTH) begin
                res.status = ST_OVER;
            end else begin
                stack_model[depth_model] = acc_model;
                depth_model++;
                acc_model = tag(cmd == OP_PUSHI ? imm : 64'(cmd - OP_PUSH0));
            end
        end else if ((cmd >= OP_ADD && cmd <= OP_GE) || cmd == OP_ULT || cmd == OP_UGE) begin
            if (depth_model == 0) begin
                res.status = ST_UNDER;
            end else begin
                depth_model--;
                m = stack_model[depth_model];
                a = untag(acc_model);
                b = untag(m);
                case (cmd)
                    OP_ADD: acc_model = tag(a + b);
                    OP_SUB: acc_model = tag(a - b);
                    OP_MUL: acc_model = tag(a * b);
                    OP_DIV, OP_MOD: begin
                        if (b == 0) begin
                            res.status = ST_DIV0;
                        end else begin
                            ma = a[63] ? -a : a;
                            mb = b[63] ? -b : b;
                            if (cmd == OP_DIV) begin
                                r = ma / mb;
                                if (a[63] != b[63]) r = -r;
                            end else begin
                                r = ma % mb;
                                if (a[63]) r = -r;
                            end
                            acc_model = tag(r);
                        end
                    end
                    OP_AND: acc_model = tag(a & b);
                    OP_OR:  acc_model = tag(a | b);
                    OP_XOR: acc_model = tag(a ^ b);
                    OP_LSL: acc_model = tag(b >= 63 ? 64'd0 : a << b);
                    OP_LSR: acc_model = tag(b >= 63 ? 64'd0 : (acc_model >> 1) >> b);
                    OP_ASR: begin
                        r = $signed(a) >>> b;
                        acc_model = tag(b >= 63 ? {64{a[63]}} : r);
                    end
                    OP_EQ:  acc_model = tf(acc_model == m);
                    OP_NE:  acc_model = tf(acc_model != m);
                    OP_LT:  acc_model = tf(signed_less(acc_model, m));
                    OP_LE:  acc_model = tf(!signed_less(m, acc_model));
                    OP_GT:  acc_model = tf(signed_less(m, acc_model));
                    OP_GE:  acc_model = tf(!signed_less(acc_model, m));
                    OP_ULT: acc_model = tf(acc_model < m);
                    default: acc_model = tf(acc_model >= m);
                endcase
            end
        end else if (cmd == OP_NEG) begin
            acc_model = tag(-untag(acc_model));
        end else if (cmd == OP_OFFSET) begin
            res.step = 33'd1;
            acc_model = tag(untag(acc_model) + imm);
        end else if (cmd == OP_ISINT) begin
            acc_model = tf(acc_model[0]);
        end else if ((cmd >= OP_BEQ && cmd <= OP_BGE) || cmd == OP_BULT || cmd == OP_BUGE) begin
            n = untag(acc_model);
            case (cmd)
                OP_BEQ:  taken = imm == n;
                OP_BNE:  taken = imm != n;
                OP_BLT:  taken = signed_less(imm, n);
                OP_BLE:  taken = !signed_less(n, imm);
                OP_BGT:  taken = signed_less(n, imm);
                OP_BGE:  taken = !signed_less(imm, n);
                OP_BULT: taken = imm < n;
                default: taken = imm >= n;
            endcase
            res.step = taken ? 33'd1 + ofs : 33'd2;
        end
        res.acc = acc_model;
        return res;
    endfunction

    always @(posedge aclk) begin
        alu_result_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            acc_model = 64'd1;
            depth_model = 0;
            fail_count <= 0;
            result_queue.delete();
        end else begin
            if (s_tvalid && s_tready) result_queue.push_back(execute(s_tdata));
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    $error("result with nothing expected: %h", m_tdata);
                    errs++;
                end else begin
                    want = result_queue.pop_front();
                    if (m_tdata[63:0] !== want.acc) begin
                        $error("acc_value expected %h got %h", want.acc, m_tdata[63:0]);
                        errs++;
                    end
                    if (m_tdata[96:64] !== want.step) begin
                        $error("index_step expected %h got %h", want.step, m_tdata[96:64]);
                        errs++;
                    end
                    if (m_tdata[98:97] !== want.status) begin
                        $error("status expected %0d got %0d", want.status, m_tdata[98:97]);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
        pending = result_queue.size();
    end
endmodule

@@ sim/tb_top.sv @@
// Stimulus and verdict for the tagged integer stack ALU.
// Depends on tisa_pkg, the ALU and tisa_checker.
module tb_top;
    import tisa_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [99:0] m_tdata;
    int          fail_count;
    int          pending;

    int  send_idle_pct = 25;   // chance in a hundred that the sender idles
    int  recv_idle_pct = 85;   // chance in a hundred that the receiver stalls
    bit  hold_off = 1'b0;      // long receiver stall requested
    int  quiet_cycles = 0;
    int  live_depth = 0;       // stack depth as the stimulus sees it

    localparam int WATCHDOG = 20000;

    tagged_integer_stack_alu uut (.*);

    tisa_checker chk (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: stall at random, or for a long stretch when asked.
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                for (n = 0; n < 400; n++) @(negedge aclk);
                hold_off = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run after too long with nothing accepted.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request and hold it until the block accepts it.
    task automatic send_request(input logic [7:0] cmd, input logic [31:0] imm,
                                input logic [31:0] ofs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ofs, imm, cmd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (cmd >= OP_PUSH0 && cmd <= OP_PUSHI && live_depth < 256) live_depth++;
        else if (((cmd >= OP_ADD && cmd <= OP_GE) || cmd == OP_ULT || cmd == OP_UGE)
                 && live_depth > 0) live_depth--;
    endtask

    function automatic logic [31:0] wild_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(70)) - 32'd5;
            default: return $urandom;
        endcase
    endfunction

    // Push a random value: a constant small or wide, sometimes widened by a multiply.
    task automatic push_value();
        send_request(OP_PUSHI, wild_word(), $urandom);
        if ($urandom_range(3) == 0) begin
            send_request(OP_PUSHI, $urandom, $urandom);
            send_request(OP_MUL, $urandom, $urandom);
        end
    endtask

    // Drop the request line and wait until every expected result has come.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic random_phase(input int count);
        int k;
        logic [7:0] op;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0: begin
                    // noise: any opcode, unknown ones included
                    op = 8'($urandom);
                    send_request(op, $urandom, $urandom);
                end
                1, 2, 3: begin
                    // binary operation on freshly pushed operands
                    push_value();
                    push_value();
                    op = 8'($urandom_range(OP_ADD, OP_GE + 2));
                    if (op > OP_GE) op = (op == OP_GE + 1) ? OP_ULT : OP_UGE;
                    if ((op == OP_DIV || op == OP_MOD) && $urandom_range(3) == 0)
                        send_request(OP_CONST0, 0, 0);
                    send_request(op, $urandom, $urandom);
                end
                4, 5: begin
                    op = 8'($urandom_range(OP_BEQ, OP_BUGE));
                    if (op == OP_ULT) op = OP_BULT;
                    if (op == OP_UGE) op = OP_BUGE;
                    send_request(op, $urandom_range(1) ? wild_word() : $urandom,
                                 $urandom);
                end
                6: send_request(8'($urandom_range(OP_CONST0, OP_PUSHI)), wild_word(),
                                $urandom);
                7: send_request($urandom_range(1) ? OP_NEG : OP_ISINT, $urandom, $urandom);
                8: send_request(OP_OFFSET, wild_word(), $urandom);
                default: begin
                    // pop one operand, sometimes past empty
                    if (live_depth < 3) begin
                        send_request(OP_ADD, $urandom, $urandom);
                    end else begin
                        send_request(8'($urandom_range(OP_AND, OP_XOR)), $urandom,
                                     $urandom);
                    end
                end
            endcase
        end
    endtask

    initial begin
        int k;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: underflow, division by zero, shift extremes, branches, overflow.
        send_request(OP_ADD, 0, 0);
        send_request(OP_PUSHI, 32'h7fff_ffff, 0);
        send_request(OP_CONST0, 0, 0);
        send_request(OP_DIV, 0, 0);
        send_request(OP_PUSHI, 32'h8000_0000, 0);
        send_request(OP_PUSHI, 70, 0);
        send_request(OP_LSL, 0, 0);
        send_request(OP_PUSHI, 32'hffff_ffff, 0);
        send_request(OP_CONSTI, 32'hffff_fffe, 0);
        send_request(OP_ASR, 0, 0);
        send_request(OP_PUSHI, 63, 0);
        send_request(OP_LSR, 0, 0);
        send_request(OP_NEG, 0, 0);
        send_request(OP_ISINT, 0, 0);
        send_request(OP_OFFSET, 32'h8000_0000, 0);
        send_request(OP_BEQ, 0, 32'h7fff_ffff);
        send_request(OP_BNE, 0, 32'h8000_0000);
        send_request(OP_BULT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_BUGE, 32'hffff_ffff, 5);
        send_request(8'd128, 0, 0);
        send_request(8'd255, 32'hffff_ffff, 32'hffff_ffff);
        // Fill the stack past full; keep the receiver off so the input stalls.
        hold_off = 1'b1;
        for (k = 0; k < 258; k++) send_request(OP_PUSH0 + 8'(k % 4), 0, 0);
        // Pause until every result is back, then empty most of the stack.
        drain();
        for (k = 0; k < 250; k++) send_request(OP_XOR, 0, 0);

        random_phase(170);
        drain();
        send_idle_pct = 85;
        recv_idle_pct = 25;
        random_phase(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(170);

        // Wait for the last results, then allow the slowest latency to pass.
        drain();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
